>>> sv/segment_intersection_point_unit_defines.svh
// Assertion macros for the segment intersection point unit.
`ifndef SEGMENT_INTERSECTION_POINT_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define SIPU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define SIPU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/sipu_pkg.sv
// Shared constants, codes and the divider chain record of the intersection unit.
package sipu_pkg;

    localparam int CW     = 16;             // coordinate width
    localparam int FB     = 8;              // fraction bits of the result
    localparam int OW     = 24;             // result coordinate width
    localparam int DW     = CW + 1;         // difference width
    localparam int PW     = 2 * DW;         // product width
    localparam int XW     = PW + 1;         // width of product differences
    localparam int DEN_W  = 2 * CW + 1;     // magnitude of denominator
    localparam int QW     = CW + FB;        // quotient width, one chain cell per bit
    localparam int NW     = CW + DEN_W + FB;// dividend width
    localparam int SW     = QW + 3;         // width of the unsaturated point
    localparam int IN_W   = 8 * CW;
    localparam int OUT_W  = 56;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_CROSS   = 2'd1,
        ST_OVERLAP = 2'd2
    } status_t;

    // Work carried from cell to cell along the divider chain.
    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic                 neg_x;
        logic                 neg_y;
        logic [DEN_W-1:0]     den;
        logic [DEN_W-1:0]     rem_x;
        logic [DEN_W-1:0]     rem_y;
        logic [QW-1:0]        lo_x;
        logic [QW-1:0]        lo_y;
        logic [QW-1:0]        q_x;
        logic [QW-1:0]        q_y;
    } div_t;

endpackage

>>> sv/sipu_front.sv
// Front stages: box tests, cross products, classification and dividend multiply.
module sipu_front
    import sipu_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [IN_W-1:0] in_data,
    output div_t            out
);

    logic signed [CW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
    logic signed [CW-1:0] axl, axh, ayl, ayh, bxl, bxh, byl, byh;
    logic box_fail, both_vert, any_in;

    assign x0 = in_data[0*CW +: CW];
    assign y0 = in_data[1*CW +: CW];
    assign x1 = in_data[2*CW +: CW];
    assign y1 = in_data[3*CW +: CW];
    assign x2 = in_data[4*CW +: CW];
    assign y2 = in_data[5*CW +: CW];
    assign x3 = in_data[6*CW +: CW];
    assign y3 = in_data[7*CW +: CW];

    always_comb
    begin
        axl = (x0 < x1) ? x0 : x1;
        axh = (x0 > x1) ? x0 : x1;
        ayl = (y0 < y1) ? y0 : y1;
        ayh = (y0 > y1) ? y0 : y1;
        bxl = (x2 < x3) ? x2 : x3;
        bxh = (x2 > x3) ? x2 : x3;
        byl = (y2 < y3) ? y2 : y3;
        byh = (y2 > y3) ? y2 : y3;
        box_fail  = (axl >= bxh) || (bxl >= axh) || (ayl >= byh) || (byl >= ayh);
        both_vert = (x0 == x1) && (x2 == x3);
        any_in = (x2 > axl && x2 < axh && y2 > ayl && y2 < ayh)
              || (x3 > axl && x3 < axh && y3 > ayl && y3 < ayh)
              || (x0 > bxl && x0 < bxh && y0 > byl && y0 < byh)
              || (x1 > bxl && x1 < bxh && y1 > byl && y1 < byh);
    end

    // Stage 1: differences and flags.
    logic                 v1_reg;
    logic signed [CW-1:0] x0_1_reg, y0_1_reg;
    logic signed [DW-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, wx_reg, wy_reg;
    logic                 skip1_reg, in1_reg;

    // Stage 2: products.
    logic                 v2_reg;
    logic signed [CW-1:0] x0_2_reg, y0_2_reg;
    logic signed [DW-1:0] dxa_2_reg, dya_2_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg, p5_reg, p6_reg;
    logic                 skip2_reg, in2_reg;

    // Stage 3: normalized denominator and parameter numerator.
    logic                 v3_reg;
    status_t              st3_reg;
    logic signed [CW-1:0] x0_3_reg, y0_3_reg;
    logic signed [DW-1:0] dxa_3_reg, dya_3_reg;
    logic [DEN_W-1:0]     den3_reg, tn3_reg;

    logic signed [XW-1:0] den0, dd, tn, un, dd_n, tn_n, un_n;
    status_t              st_next;

    always_comb
    begin
        den0 = XW'(p1_reg) - XW'(p2_reg);
        dd   = -den0;
        tn   = XW'(p6_reg) - XW'(p5_reg);
        un   = XW'(p4_reg) - XW'(p3_reg);
        if (dd < 0)
        begin
            dd_n = -dd;
            tn_n = -tn;
            un_n = -un;
        end
        else
        begin
            dd_n = dd;
            tn_n = tn;
            un_n = un;
        end
        if (skip2_reg)
            st_next = ST_NONE;
        else if (den0 == 0)
            st_next = (tn == 0 && un == 0 && in2_reg) ? ST_OVERLAP : ST_NONE;
        else if (tn_n < 0 || tn_n > dd_n || un_n < 0 || un_n > dd_n)
            st_next = ST_NONE;
        else
            st_next = ST_CROSS;
    end

    // Stage 4: dividend = |direction| * tn, scaled by the fraction bits.
    logic [DW-1:0]            ax_abs, ay_abs;
    logic [CW+DEN_W-1:0]      px, py;
    logic [NW-1:0]            nx, ny;

    always_comb
    begin
        ax_abs = dxa_3_reg[DW-1] ? DW'(-dxa_3_reg) : DW'(dxa_3_reg);
        ay_abs = dya_3_reg[DW-1] ? DW'(-dya_3_reg) : DW'(dya_3_reg);
        px = ax_abs[CW-1:0] * tn3_reg;
        py = ay_abs[CW-1:0] * tn3_reg;
        nx = {px, {FB{1'b0}}};
        ny = {py, {FB{1'b0}}};
    end

    // Only the valid flags are reset; the data fields of out simply hold meanwhile.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out.valid <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out.valid <= v3_reg;

            out.status <= st3_reg;
            out.base_x <= x0_3_reg;
            out.base_y <= y0_3_reg;
            out.neg_x  <= dxa_3_reg[DW-1];
            out.neg_y  <= dya_3_reg[DW-1];
            out.den    <= den3_reg;
            out.rem_x  <= nx[NW-1:QW];
            out.rem_y  <= ny[NW-1:QW];
            out.lo_x   <= nx[QW-1:0];
            out.lo_y   <= ny[QW-1:0];
            out.q_x    <= '0;
            out.q_y    <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x0_1_reg  <= x0;
            y0_1_reg  <= y0;
            dxa_reg   <= DW'(x1) - DW'(x0);
            dya_reg   <= DW'(y1) - DW'(y0);
            dxb_reg   <= DW'(x3) - DW'(x2);
            dyb_reg   <= DW'(y3) - DW'(y2);
            wx_reg    <= DW'(x2) - DW'(x0);
            wy_reg    <= DW'(y2) - DW'(y0);
            skip1_reg <= box_fail || both_vert;
            in1_reg   <= any_in;

            x0_2_reg  <= x0_1_reg;
            y0_2_reg  <= y0_1_reg;
            dxa_2_reg <= dxa_reg;
            dya_2_reg <= dya_reg;
            p1_reg    <= dya_reg * dxb_reg;
            p2_reg    <= dyb_reg * dxa_reg;
            p3_reg    <= dxa_reg * wy_reg;
            p4_reg    <= dya_reg * wx_reg;
            p5_reg    <= dxb_reg * wy_reg;
            p6_reg    <= dyb_reg * wx_reg;
            skip2_reg <= skip1_reg;
            in2_reg   <= in1_reg;

            st3_reg   <= st_next;
            x0_3_reg  <= x0_2_reg;
            y0_3_reg  <= y0_2_reg;
            dxa_3_reg <= dxa_2_reg;
            dya_3_reg <= dya_2_reg;
            den3_reg  <= dd_n[DEN_W-1:0];
            tn3_reg   <= tn_n[DEN_W-1:0];
        end
    end

endmodule

>>> sv/sipu_div_cell.sv
// One cell of the divider chain: settles one quotient bit for both coordinates.
module sipu_div_cell
    import sipu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  div_t in,
    output div_t out
);

    logic [DEN_W:0]   tx, ty;
    logic             gex, gey;
    logic [DEN_W-1:0] rx_next, ry_next;

    always_comb
    begin
        tx  = {in.rem_x, in.lo_x[QW-1]};
        ty  = {in.rem_y, in.lo_y[QW-1]};
        gex = tx >= {1'b0, in.den};
        gey = ty >= {1'b0, in.den};
        rx_next = gex ? DEN_W'(tx - {1'b0, in.den}) : tx[DEN_W-1:0];
        ry_next = gey ? DEN_W'(ty - {1'b0, in.den}) : ty[DEN_W-1:0];
    end

    // Only the valid flag is reset; the data fields hold during reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out.valid <= 1'b0;
        else if (adv)
        begin
            out.valid  <= in.valid;
            out.status <= in.status;
            out.base_x <= in.base_x;
            out.base_y <= in.base_y;
            out.neg_x  <= in.neg_x;
            out.neg_y  <= in.neg_y;
            out.den    <= in.den;
            out.rem_x  <= rx_next;
            out.rem_y  <= ry_next;
            out.lo_x   <= {in.lo_x[QW-2:0], 1'b0};
            out.lo_y   <= {in.lo_y[QW-2:0], 1'b0};
            out.q_x    <= {in.q_x[QW-2:0], gex};
            out.q_y    <= {in.q_y[QW-2:0], gey};
        end
    end

endmodule

>>> sv/segment_intersection_point_unit.sv
// Pipeline: 4 front stages, 24 divider cells and one output register lie between input
// transfer and result, and all of them hold while the output is stalled.
// Throughput: one segment pair per cycle; the 24-cell divider chain takes a new
// dividend every cycle and the whole pipeline holds while the output is stalled.
// Reset: rst_n clears all valid flags asynchronously; data registers are not reset.
// Top level of the segment intersection point unit.
`include "segment_intersection_point_unit_defines.svh"
module segment_intersection_point_unit
    import sipu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // ax0, ay0, ax1, ay1, bx0, by0, bx1, by1
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, cross_x, cross_y, zero pad
);

    logic adv;
    div_t chain [QW+1];

    logic                 m_tvalid_reg;
    status_t              status_reg;
    logic signed [OW-1:0] cross_x_reg, cross_y_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    sipu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .out      (chain[0])
    );

    for (genvar g = 0; g < QW; g++)
    begin : g_cell
        sipu_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .in    (chain[g]),
            .out   (chain[g+1])
        );
    end

    div_t                 last;
    logic signed [SW-1:0] off_x, off_y, sum_x, sum_y;
    logic signed [OW-1:0] sat_x, sat_y;

    localparam logic signed [SW-1:0] MAX_V = SW'((1 << (OW - 1)) - 1);
    localparam logic signed [SW-1:0] MIN_V = -SW'(1 << (OW - 1));

    always_comb
    begin
        last  = chain[QW];
        // A negative direction rounds the magnitude up so the point stays floored.
        off_x = last.neg_x ? -(SW'(last.q_x) + SW'(last.rem_x != '0)) : SW'(last.q_x);
        off_y = last.neg_y ? -(SW'(last.q_y) + SW'(last.rem_y != '0)) : SW'(last.q_y);
        sum_x = {{(SW-CW-FB){last.base_x[CW-1]}}, last.base_x, {FB{1'b0}}} + off_x;
        sum_y = {{(SW-CW-FB){last.base_y[CW-1]}}, last.base_y, {FB{1'b0}}} + off_y;
        if (sum_x > MAX_V)
            sat_x = MAX_V[OW-1:0];
        else if (sum_x < MIN_V)
            sat_x = MIN_V[OW-1:0];
        else
            sat_x = sum_x[OW-1:0];
        if (sum_y > MAX_V)
            sat_y = MAX_V[OW-1:0];
        else if (sum_y < MIN_V)
            sat_y = MIN_V[OW-1:0];
        else
            sat_y = sum_y[OW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg  <= last.status;
            cross_x_reg <= (last.status == ST_CROSS) ? sat_x : '0;
            cross_y_reg <= (last.status == ST_CROSS) ? sat_y : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_W - 2 - 2 * OW){1'b0}}, cross_y_reg, cross_x_reg, status_reg};

    `SIPU_ASSERT_IMP(a_status_legal, m_tvalid, (status_reg == ST_NONE) || (status_reg == ST_CROSS) || (status_reg == ST_OVERLAP))
    `SIPU_ASSERT_IMP(a_zero_point, m_tvalid && status_reg != ST_CROSS, cross_x_reg == '0 && cross_y_reg == '0)
    `SIPU_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

endmodule
